>>> src/kci_pkg.sv
// Shared types and constants for the keyframe colour interpolator.
// No dependencies; imported by keyframe_colour_interpolator.
`timescale 1ns / 1ps
`default_nettype none

package kci_pkg;

    localparam int CH_W     = 12;
    localparam int TIME_W   = 16;
    localparam int LIFE_W   = 32;
    localparam int KEY_W    = 64;
    localparam int DATA_W   = 64;
    localparam int ADDR_W   = 6;
    localparam int IDX_W    = 3;
    localparam int MAX_KEY_REGS = 4;

    // register indexes (byte address = 8 * index)
    localparam logic [IDX_W-1:0] REG_PERIOD = 3'd0;
    localparam logic [IDX_W-1:0] REG_KEY0   = 3'd1;

    // element 3 is red, element 0 is alpha
    typedef logic [3:0][CH_W-1:0] colour_t;

    localparam colour_t          WHITE     = '1;
    localparam logic [KEY_W-1:0] KEY_RESET = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_CHECK,
        ST_SEARCH,
        ST_FRAC,
        ST_MUL,
        ST_ADD,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

>>> src/keyframe_colour_interpolator.sv
// Keyframe colour interpolator: life counter, cycle phase, keyframe blend.
// Depends on kci_pkg for colour type, register indexes and state encoding.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Input channel (in_valid/in_ready, time_delta): one item per frame. The
//   delta is added to a saturating 32-bit life counter at acceptance.
//   Output channel (out_valid/out_ready): exactly one item per input item,
//   carrying the colour register (red, green, blue, alpha) and updated.
//   APB port: byte address 8*i holds register i (cycle_period, then the key
//   registers); writes land on the access cycle, reads return the value.
// Sequencing
//   One item at a time. A disabled item (period or life zero) goes
//   straight to the done state. Otherwise one restoring divider, one bit
//   per cycle, does 48 steps for the phase (life * 65536 / period,
//   remainder form) and 16 more for the blend fraction; the segment search
//   walks one segment per cycle and the blend runs one multiplier over the
//   four channels, a multiply state then an add state for each channel.
// Reset: life 0, period 0, keys all ones, colour white, output empty.
// Stall: the finished result sits in the output register; the next item is
//   accepted meanwhile and waits in its final state until the register frees.
module keyframe_colour_interpolator #(
    parameter int STAGES = 4
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // item input
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [kci_pkg::TIME_W-1:0]  time_delta,
    // item output
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [kci_pkg::CH_W-1:0]         red,
    output logic [kci_pkg::CH_W-1:0]         green,
    output logic [kci_pkg::CH_W-1:0]         blue,
    output logic [kci_pkg::CH_W-1:0]         alpha,
    output logic                             updated,
    // configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [kci_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [kci_pkg::DATA_W-1:0]  pwdata,
    output logic [kci_pkg::DATA_W-1:0]       prdata,
    output logic                             pready
);

    import kci_pkg::*;

    // keys beyond the register file keep their reset word
    localparam int KEY_REGS  = (STAGES < MAX_KEY_REGS) ? STAGES : MAX_KEY_REGS;
    localparam int STAGE_W   = $clog2(STAGES);
    localparam int STEP_W    = 6;
    localparam logic [STAGE_W-1:0] SEG_LAST  = STAGE_W'(STAGES - 2);
    localparam logic [STAGE_W-1:0] KEY_LAST  = STAGE_W'(STAGES - 1);
    localparam logic [STEP_W-1:0]  PHASE_STEPS = STEP_W'(LIFE_W + TIME_W - 1);
    localparam logic [STEP_W-1:0]  FRAC_STEPS  = STEP_W'(TIME_W - 1);

    // ---------------- registers ----------------
    state_t                state_reg, state_next;
    logic [TIME_W-1:0]     period_reg;
    logic [KEY_W-1:0]      key_reg [KEY_REGS];
    logic [LIFE_W-1:0]     life_reg, life_next;
    colour_t               colour_reg, colour_next;
    logic                  out_valid_reg, out_valid_next;
    logic [STEP_W-1:0]     step_reg, step_next;

    // datapath: divider, segment search, blend and result registers
    logic [TIME_W-1:0]     rem_reg, rem_next;
    logic [LIFE_W-1:0]     dvd_reg, dvd_next;
    logic [TIME_W-1:0]     quo_reg, quo_next;
    logic [TIME_W-1:0]     div_reg, div_next;
    logic [TIME_W-1:0]     phase_reg, phase_next;
    logic [STAGE_W-1:0]    seg_reg, seg_next;
    logic [1:0]            ch_reg, ch_next;
    logic signed [29:0]    prod_reg, prod_next;
    logic                  upd_reg, upd_next;
    colour_t               res_colour_reg, res_colour_next;
    logic                  res_upd_reg, res_upd_next;

    // ---------------- combinational ----------------
    logic [KEY_W-1:0]      key_word [STAGES];
    logic                  cfg_wr;
    logic [IDX_W-1:0]      cfg_idx;
    logic [LIFE_W:0]       life_sum;
    logic [LIFE_W-1:0]     life_sat;
    logic [TIME_W:0]       trial;
    logic [TIME_W:0]       trial_diff;
    logic                  trial_ge;
    logic [TIME_W-1:0]     rem_step;
    logic [TIME_W-1:0]     t_lo;
    logic [TIME_W-1:0]     t_hi;
    logic [TIME_W-1:0]     t_first;
    logic [TIME_W-1:0]     t_last;
    colour_t               key_a;
    colour_t               key_b;
    logic signed [12:0]    ch_diff;
    logic signed [16:0]    frac_s;
    logic signed [13:0]    ch_sum;

    generate
        for (genvar k = 0; k < STAGES; k++) begin : g_key
            if (k < KEY_REGS) begin : g_reg
                assign key_word[k] = key_reg[k];
            end else begin : g_const
                assign key_word[k] = KEY_RESET;
            end
        end
    endgenerate

    // APB decode
    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_W-1:ADDR_W-IDX_W];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb
    begin
        prdata = '0;
        if (cfg_idx == REG_PERIOD)
        begin
            prdata = {{(DATA_W-TIME_W){1'b0}}, period_reg};
        end
        for (int k = 0; k < KEY_REGS; k++)
        begin
            if (cfg_idx == IDX_W'(int'(REG_KEY0) + k))
            begin
                prdata = key_reg[k];
            end
        end
    end

    // saturating life update
    assign life_sum = {1'b0, life_reg} + {{(LIFE_W+1-TIME_W){1'b0}}, time_delta};
    assign life_sat = life_sum[LIFE_W] ? '1 : life_sum[LIFE_W-1:0];

    // shared restoring divider, one quotient bit per step
    assign trial      = {rem_reg, dvd_reg[LIFE_W-1]};
    assign trial_diff = trial - {1'b0, div_reg};
    assign trial_ge   = (trial >= {1'b0, div_reg});
    assign rem_step   = trial_ge ? trial_diff[TIME_W-1:0] : trial[TIME_W-1:0];

    // keyframe taps
    assign t_first = key_word[0][KEY_W-1:KEY_W-TIME_W];
    assign t_last  = key_word[KEY_LAST][KEY_W-1:KEY_W-TIME_W];
    assign t_lo    = key_word[seg_reg][KEY_W-1:KEY_W-TIME_W];
    assign t_hi    = key_word[seg_reg + 1'b1][KEY_W-1:KEY_W-TIME_W];
    assign key_a   = colour_t'(key_word[seg_reg][4*CH_W-1:0]);
    assign key_b   = colour_t'(key_word[seg_reg + 1'b1][4*CH_W-1:0]);

    // blend: a + floor((b - a) * f / 65536)
    assign ch_diff = $signed({1'b0, key_b[ch_reg]}) - $signed({1'b0, key_a[ch_reg]});
    assign frac_s  = $signed({1'b0, quo_reg});
    assign ch_sum  = $signed({2'b00, key_a[ch_reg]}) + $signed(prod_reg[29:16]);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        life_next       = life_reg;
        colour_next     = colour_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        step_next       = step_reg;
        rem_next        = rem_reg;
        dvd_next        = dvd_reg;
        quo_next        = quo_reg;
        div_next        = div_reg;
        phase_next      = phase_reg;
        seg_next        = seg_reg;
        ch_next         = ch_reg;
        prod_next       = prod_reg;
        upd_next        = upd_reg;
        res_colour_next = res_colour_reg;
        res_upd_next    = res_upd_reg;
        in_ready        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    life_next = life_sat;
                    if (life_sat == '0 || period_reg == '0)
                    begin
                        upd_next   = 1'b0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        rem_next   = '0;
                        dvd_next   = life_sat;
                        div_next   = period_reg;
                        step_next  = PHASE_STEPS;
                        state_next = ST_DIVIDE;
                    end
                end
            end
            ST_DIVIDE, ST_FRAC:
            begin
                rem_next = rem_step;
                dvd_next = {dvd_reg[LIFE_W-2:0], 1'b0};
                quo_next = {quo_reg[TIME_W-2:0], trial_ge};
                if (step_reg == '0)
                begin
                    if (state_reg == ST_DIVIDE)
                    begin
                        state_next = ST_CHECK;
                    end
                    else
                    begin
                        ch_next    = 2'd3;
                        state_next = ST_MUL;
                    end
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_CHECK:
            begin
                phase_next = quo_reg;
                if (quo_reg <= t_first)
                begin
                    colour_next = colour_t'(key_word[0][4*CH_W-1:0]);
                    upd_next    = 1'b1;
                    state_next  = ST_DONE;
                end
                else if (quo_reg >= t_last)
                begin
                    colour_next = colour_t'(key_word[KEY_LAST][4*CH_W-1:0]);
                    upd_next    = 1'b1;
                    state_next  = ST_DONE;
                end
                else
                begin
                    seg_next   = '0;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (phase_reg >= t_lo && phase_reg < t_hi)
                begin
                    rem_next   = phase_reg - t_lo;
                    dvd_next   = '0;
                    div_next   = t_hi - t_lo;
                    step_next  = FRAC_STEPS;
                    state_next = ST_FRAC;
                end
                else if (seg_reg == SEG_LAST)
                begin
                    // keys out of order: hold colour
                    upd_next   = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    seg_next = seg_reg + 1'b1;
                end
            end
            ST_MUL:
            begin
                prod_next  = 30'(ch_diff) * 30'(frac_s);
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                colour_next[ch_reg] = ch_sum[CH_W-1:0];
                if (ch_reg == 2'd0)
                begin
                    upd_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    ch_next    = ch_reg - 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    res_colour_next = colour_reg;
                    res_upd_next    = upd_reg;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            life_reg      <= '0;
            colour_reg    <= WHITE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            period_reg    <= '0;
            for (int k = 0; k < KEY_REGS; k++)
            begin
                key_reg[k] <= KEY_RESET;
            end
        end
        else
        begin
            state_reg     <= state_next;
            life_reg      <= life_next;
            colour_reg    <= colour_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            if (cfg_wr && cfg_idx == REG_PERIOD)
            begin
                period_reg <= pwdata[TIME_W-1:0];
            end
            for (int k = 0; k < KEY_REGS; k++)
            begin
                if (cfg_wr && cfg_idx == IDX_W'(int'(REG_KEY0) + k))
                begin
                    key_reg[k] <= pwdata;
                end
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        rem_reg        <= rem_next;
        dvd_reg        <= dvd_next;
        quo_reg        <= quo_next;
        div_reg        <= div_next;
        phase_reg      <= phase_next;
        seg_reg        <= seg_next;
        ch_reg         <= ch_next;
        prod_reg       <= prod_next;
        upd_reg        <= upd_next;
        res_colour_reg <= res_colour_next;
        res_upd_reg    <= res_upd_next;
    end

    assign out_valid = out_valid_reg;
    assign red       = res_colour_reg[3];
    assign green     = res_colour_reg[2];
    assign blue      = res_colour_reg[1];
    assign alpha     = res_colour_reg[0];
    assign updated   = res_upd_reg;

`ifndef SYNTH
    // one item at a time
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("item accepted while busy");

    // divider remainder stays below divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE || state_reg == ST_FRAC) |-> (rem_reg < div_reg))
        else $error("divider remainder out of range");

    // a held result leaves the colour untouched
    a_hold_colour: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !upd_reg) |-> (colour_reg == $past(colour_reg)))
        else $error("colour changed on held item");

    // step counter exhausted before phase check
    a_step_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK) |-> (step_reg == '0))
        else $error("phase check before divide finished");
`endif

endmodule

`default_nettype wire
